FILE: rtl/wear_leveled_seed_counter_unit_macros.svh
// Assertion macros used by the seed counter sequencer.
`ifndef WEAR_LEVELED_SEED_COUNTER_UNIT_MACROS_SVH
`define WEAR_LEVELED_SEED_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WLSC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wlsc check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define WLSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wlsc check failed: next-cycle implication");

`endif

FILE: rtl/wlsc_pkg.sv
// Types and constants of the wear-leveled seed counter.
package wlsc_pkg;

	localparam int CELLS = 16;
	localparam int IDX_W = $clog2(CELLS);
	localparam int LEN_W = $clog2(CELLS + 1);
	localparam int WORD_W = 32;
	localparam int CFG_W = 5;
	localparam logic [WORD_W-1:0] ZERO_SEED_SUBST = 32'hAAAA_AAAA;
	localparam logic [WORD_W-1:0] ERASED_WORD = '1;
	localparam logic OP_SEED = 1'b0;
	localparam logic OP_PRELOAD = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [3:0]  cell_index;
		logic [31:0] cell_value;
	} req_t;

	typedef struct packed {
		logic [31:0] seed_value;
		logic [3:0]  slot_written;
	} rsp_t;

	typedef struct packed {
		logic              wr_en;
		logic [IDX_W-1:0]  wr_addr;
		logic [WORD_W-1:0] wr_data;
		logic              rd_en;
		logic [IDX_W-1:0]  rd_addr;
	} mem_req_t;

endpackage

FILE: rtl/wlsc_mem.sv
// Cell store: one write and one registered read port, erased entries read as all ones.
module wlsc_mem
	import wlsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mem_req_t          mem_req,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] cells_mem [CELLS];
	logic [CELLS-1:0]  valid_q;
	logic [WORD_W-1:0] rdata_q;
	logic              rhit_q;

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			cells_mem[mem_req.wr_addr] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			rdata_q <= cells_mem[mem_req.rd_addr];
		end
	end

	// Valid bits stand in for the erase: a cell never written reads as erased.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rhit_q <= 1'b0;
		end else begin
			if (mem_req.wr_en) begin
				valid_q[mem_req.wr_addr] <= 1'b1;
			end
			if (mem_req.rd_en) begin
				rhit_q <= valid_q[mem_req.rd_addr];
			end
		end
	end

	assign rdata = rhit_q ? rdata_q : ERASED_WORD;

endmodule

FILE: rtl/wlsc_ctrl.sv
// Sequencer: walks the ring one read per cycle, writes the count back, holds the result.
module wlsc_ctrl
	import wlsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  req_t              in_data,
	input  logic [CFG_W-1:0]  region_len,
	input  logic [WORD_W-1:0] mem_rdata,
	output mem_req_t          mem_req,
	output logic              out_valid,
	input  logic              out_ready,
	output rsp_t              out_data
);

	`include "wear_leveled_seed_counter_unit_macros.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD0  = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam logic [1:0] ST_WR   = 2'd3;

	logic [1:0]        state_q;
	logic              out_valid_q;
	rsp_t              out_data_q;
	logic [WORD_W-1:0] count_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  slot_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  len_act;
	logic [LEN_W-1:0]  i_next;
	logic [WORD_W-1:0] count_inc;
	logic              acc;
	logic              out_free;
	logic              run_on;

	always_comb begin
		if (CFG_W'(CELLS) < region_len) begin
			len_act = LEN_W'(CELLS);
		end else begin
			len_act = LEN_W'(region_len);
		end
		in_ready = (state_q == ST_IDLE);
		acc = in_valid && in_ready;
		count_inc = count_q + WORD_W'(1);
		i_next = LEN_W'(i_q) + LEN_W'(1);
		out_free = !out_valid_q || out_ready;
		run_on = (count_inc == mem_rdata) && (i_next < len_q);

		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (acc && in_data.operation == OP_PRELOAD) begin
					mem_req.wr_en = (32'(in_data.cell_index) < CELLS);
					mem_req.wr_addr = IDX_W'(in_data.cell_index);
					mem_req.wr_data = in_data.cell_value;
				end else if (acc) begin
					mem_req.rd_en = 1'b1;
					mem_req.rd_addr = '0;
				end
			end
			ST_RD0: begin
				mem_req.rd_en = (len_q > LEN_W'(1));
				mem_req.rd_addr = IDX_W'(1);
			end
			ST_WALK: begin
				mem_req.rd_en = run_on;
				mem_req.rd_addr = i_next[IDX_W-1:0];
			end
			ST_WR: begin
				mem_req.wr_en = out_free;
				mem_req.wr_addr = slot_q;
				mem_req.wr_data = count_q;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc && in_data.operation == OP_SEED) begin
						state_q <= ST_RD0;
					end
				end
				ST_RD0: begin
					state_q <= (len_q > LEN_W'(1)) ? ST_WALK : ST_WR;
				end
				ST_WALK: begin
					if (!run_on) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_WR && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				len_q <= len_act;
			end
			ST_RD0: begin
				count_q <= mem_rdata;
				slot_q <= '0;
				i_q <= IDX_W'(1);
			end
			ST_WALK: begin
				count_q <= count_inc;
				if (count_inc != mem_rdata) begin
					slot_q <= i_q;
				end else if (run_on) begin
					i_q <= i_next[IDX_W-1:0];
				end else begin
					slot_q <= '0;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_WR && out_free) begin
			out_data_q.seed_value <= (count_q == '0) ? ZERO_SEED_SUBST : count_q;
			out_data_q.slot_written <= 4'(slot_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	`WLSC_ASSERT_IMPL(a_no_rw_same_cell, mem_req.rd_en && mem_req.wr_en,
		mem_req.rd_addr != mem_req.wr_addr)
	`WLSC_ASSERT_IMPL(a_walk_in_region, state_q == ST_WALK, LEN_W'(i_q) < len_q)
	`WLSC_ASSERT_NEXT(a_result_loaded, state_q == ST_WR && out_free, out_valid_q)
	`WLSC_ASSERT_IMPL(a_seed_nonzero, out_valid_q, out_data_q.seed_value != '0)

endmodule

FILE: rtl/wear_leveled_seed_counter_unit.sv
// Top level of the wear-leveled seed counter: configuration register, sequencer and cell store.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   in      | in_valid, in_ready, in_data     | request in
//   out     | out_valid, out_ready, out_data  | result out
//   cfg     | cfg_we, cfg_wdata               | write only
//
// A preload request writes its cell as it is accepted and gives no result.
// A seed request reads cell 0, compares one further cell at a time until a mismatch
// or the end of the region, and then writes the count back; the cells are read one at
// a time through the single read port of the cell store.
// Reset clears the valid bits of the store at once, so erased cells read all ones; no sweep.
// A result waiting on out_ready holds the sequencer in its write-back step only.
module wear_leveled_seed_counter_unit
	import wlsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  req_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rsp_t             out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [CFG_W-1:0]  region_length_q;
	mem_req_t          mem_req;
	logic [WORD_W-1:0] mem_rdata;

	// Hold the ring length; the user must write it only while idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_length_q <= CFG_W'(16);
		end else if (cfg_we) begin
			region_length_q <= cfg_wdata;
		end
	end

	// Sequence each request: a preload writes its cell; a seed reads, compares and advances, then writes the count back.
	wlsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.region_len (region_length_q),
		.mem_rdata  (mem_rdata),
		.mem_req    (mem_req),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// Keep the ring of cells.
	wlsc_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rdata   (mem_rdata)
	);

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the wear-leveled seed counter.
`timescale 1ns / 100ps

module tb;
	import wlsc_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int CYCLE_LIMIT = 1000000;
	// A seed request reads at most CELLS cells, cell 0 among them, plus the write-back.
	localparam int SETTLE_CYCLES = CELLS + 8;
	localparam int ITEMS_PER_PACE = 50;

	// Tracks the cell ring and queues the seeds the block must return.
	class seed_tracker;
		logic [WORD_W-1:0] cells [CELLS];
		logic [CFG_W-1:0]  region;
		rsp_t              pending_seeds [$];
		int                errors;
		int                seeds_checked;

		function new();
			for (int i = 0; i < CELLS; i++) begin
				cells[i] = ERASED_WORD;
			end
			region = CFG_W'(16);
			errors = 0;
			seeds_checked = 0;
		endfunction

		function void set_region(logic [CFG_W-1:0] len);
			region = len;
		endfunction

		// Apply one accepted request and queue the seed it must produce.
		function void note_request(req_t r);
			int                walk_len;
			int                slot;
			bit                broke;
			logic [WORD_W-1:0] count;
			rsp_t              seed;
			if (r.operation == OP_PRELOAD) begin
				if (int'(r.cell_index) < CELLS) begin
					cells[r.cell_index] = r.cell_value;
				end
				return;
			end
			walk_len = (int'(region) > CELLS) ? CELLS : int'(region);
			count = cells[0];
			slot = 0;
			broke = 1'b0;
			for (int i = 1; i < walk_len && !broke; i++) begin
				count = count + 1;
				if (count != cells[i]) begin
					slot = i;
					broke = 1'b1;
				end
			end
			cells[slot] = count;
			seed.seed_value = (count == '0) ? ZERO_SEED_SUBST : count;
			seed.slot_written = slot[3:0];
			pending_seeds.push_back(seed);
		endfunction

		// Compare one delivered seed with the oldest one still owed.
		function void check_seed(rsp_t got);
			rsp_t want;
			if (pending_seeds.size() == 0) begin
				$display("%0t unexpected seed: got seed_value %h slot_written %0d",
					$time, got.seed_value, got.slot_written);
				errors++;
				return;
			end
			want = pending_seeds.pop_front();
			seeds_checked++;
			if (got.seed_value !== want.seed_value) begin
				$display("%0t seed_value mismatch: expected %h, actual %h",
					$time, want.seed_value, got.seed_value);
				errors++;
			end
			if (got.slot_written !== want.slot_written) begin
				$display("%0t slot_written mismatch: expected %0d, actual %0d",
					$time, want.slot_written, got.slot_written);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_seeds.size();
		endfunction

		// Report every seed that never came back.
		function void close_out();
			while (pending_seeds.size() != 0) begin
				$display("%0t missing seed: expected seed_value %h slot_written %0d", $time,
					pending_seeds[0].seed_value, pending_seeds[0].slot_written);
				void'(pending_seeds.pop_front());
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	req_t             in_data;
	logic             out_valid;
	logic             out_ready;
	rsp_t             out_data;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	seed_tracker book;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          requests_sent;
	int          region_settings;
	longint      cycle_count;

	wear_leveled_seed_counter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Stall the result channel at the rate of the current pacing mode.
	always @(negedge clk) begin
		out_ready = ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// Check every seed taken by the receiver; sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			book.check_seed(out_data);
		end
	end

	// Give up on a hung block.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d seeds outstanding",
				cycle_count, book.outstanding());
			$display("tb NOT OK");
			$finish;
		end
	end

	// Drive one request. Enter and leave at a falling edge; valid stays high
	// on exit so that a back-to-back request does not drop it.
	task automatic send_req(input logic op, input logic [3:0] idx, input logic [31:0] val);
		req_t r;
		r.operation = op;
		r.cell_index = idx;
		r.cell_value = val;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = r;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		book.note_request(r);
		requests_sent++;
		@(negedge clk);
	endtask

	// Hold off new requests until every owed seed has been delivered.
	task automatic drain_seeds();
		in_valid = 1'b0;
		while (book.outstanding() != 0) begin
			@(negedge clk);
		end
	endtask

	// Write the region length once the block has gone quiet.
	task automatic write_region(input logic [CFG_W-1:0] len);
		drain_seeds();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = len;
		book.set_region(len);
		region_settings++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Favor words near the wrap point and near zero, where the count rolls over.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(3, 0))
			0: return 32'($urandom());
			1: return 32'($urandom_range(20, 0));
			2: return 32'hFFFF_FFFF - 32'($urandom_range(20, 0));
			default: return {$urandom_range(1, 0) ? 16'hFFFF : 16'h0000, 16'($urandom())};
		endcase
	endfunction

	// Run random traffic for one pacing mode; most of it is preloaded runs of
	// consecutive counts followed by seeds, so the walk reaches deep cells.
	task automatic random_traffic(input int count);
		int          done;
		int          run_len;
		int          bad_cell;
		int          seeds;
		logic [31:0] start;
		done = 0;
		while (done < count) begin
			if ($urandom_range(99, 0) < 3) begin
				drain_seeds();
			end
			case ($urandom_range(99, 0)) inside
				[0:44]: begin
					run_len = $urandom_range(CELLS, 1);
					start = pick_word();
					bad_cell = ($urandom_range(99, 0) < 30) ? $urandom_range(run_len - 1, 0) : -1;
					for (int i = 0; i < run_len; i++) begin
						send_req(OP_PRELOAD, 4'(i),
							(i == bad_cell) ? start + 32'(i) + 32'($urandom_range(5, 1))
							: start + 32'(i));
					end
					seeds = $urandom_range(3, 1);
					repeat (seeds) send_req(OP_SEED, 4'($urandom()), 32'($urandom()));
					done += run_len + seeds;
				end
				[45:74]: begin
					seeds = $urandom_range(4, 1);
					repeat (seeds) send_req(OP_SEED, 4'($urandom()), 32'($urandom()));
					done += seeds;
				end
				default: begin
					send_req(OP_PRELOAD, 4'($urandom()), pick_word());
					done++;
				end
			endcase
		end
	endtask

	initial begin
		logic [CFG_W-1:0] region_plan [10];
		int               send_plan [4];
		int               recv_plan [4];

		region_plan = '{5'd16, 5'd2, 5'd0, 5'd1, 5'd31, 5'd17, 5'd5, 5'd0, 5'd0, 5'd0};
		send_plan = '{0, 77, 0, 12};
		recv_plan = '{0, 0, 77, 12};
		for (int i = 7; i < 10; i++) begin
			region_plan[i] = CFG_W'($urandom_range(16, 2));
		end

		// Drive every input to a known value and hold reset, then release it at a falling edge.
		book = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		requests_sent = 0;
		region_settings = 0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: walk the erased store at the reset region length of 16.
		// Cell 0 holds all ones, so the count wraps to zero and comes back substituted.
		send_req(OP_SEED, 4'h0, 32'h0);
		send_req(OP_SEED, 4'hF, 32'hFFFF_FFFF);
		// Fill every cell with a run that wraps through zero; the whole region
		// matches, so the count lands back in cell 0.
		for (int i = 0; i < CELLS; i++) begin
			send_req(OP_PRELOAD, 4'(i), 32'hFFFF_FFF8 + 32'(i));
		end
		send_req(OP_SEED, 4'h0, 32'h0);
		send_req(OP_SEED, 4'h0, 32'h0);
		// Pause the sender until every seed is back.
		drain_seeds();
		send_req(OP_PRELOAD, 4'h0, 32'h0000_0000);
		send_req(OP_SEED, 4'hA, 32'h5555_5555);
		send_req(OP_PRELOAD, 4'hF, 32'hFFFF_FFFF);
		send_req(OP_SEED, 4'h5, 32'hAAAA_AAAA);

		// Sweep region lengths, including empty walks and values above the store,
		// and run every pacing mode under each.
		foreach (region_plan[r]) begin
			write_region(region_plan[r]);
			if (region_plan[r] <= 1) begin
				// Single-cell region: zero in cell 0 must come back substituted.
				send_req(OP_PRELOAD, 4'h0, 32'h0);
				send_req(OP_SEED, 4'h3, 32'h0);
			end
			for (int p = 0; p < 4; p++) begin
				send_idle_pct = send_plan[p];
				recv_stall_pct = recv_plan[p];
				random_traffic(ITEMS_PER_PACE);
			end
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end

		// Drop valid, collect the last seeds, then let the block settle.
		drain_seeds();
		repeat (SETTLE_CYCLES) @(posedge clk);
		book.close_out();

		$display("covered %0d requests with %0d seeds checked", requests_sent,
			book.seeds_checked);
		$display("across %0d region lengths, each under four handshake pacing modes",
			region_settings);
		if (book.errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/wlsc_pkg.sv
rtl/wlsc_mem.sv
rtl/wlsc_ctrl.sv
rtl/wear_leveled_seed_counter_unit.sv
sim/tb.sv
